### hdl/cbcr_pkg.sv
`timescale 1ns / 1ps

package cbcr_pkg;

    localparam int SECTOR_W = 32;
    localparam int ENTRY_W  = 6;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_MISS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOUCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    localparam logic ACT_WRITE_BACK = 1'b0;
    localparam logic ACT_READ       = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WB,
        ST_RD,
        ST_FL_SCAN,
        ST_FL_LAST
    } t_state;

    typedef struct packed {
        logic                valid;
        logic                action;
        logic [SECTOR_W-1:0] sector;
        logic [ENTRY_W-1:0]  entry;
        logic                last;
    } t_beat;

endpackage

### hdl/cbcr_tag_ram.sv
`timescale 1ns / 1ps

module cbcr_tag_ram
    import cbcr_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [SECTOR_W-1:0] i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [SECTOR_W-1:0] o_rdata
);

    logic [SECTOR_W-1:0] r_mem [DEPTH];
    logic [SECTOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // rdata holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cbcr_seq.sv
`timescale 1ns / 1ps

module cbcr_seq
    import cbcr_pkg::*;
#(
    parameter int NUM_ENTRIES = 64,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SECTOR_W-1:0] i_sector,
    input  logic [ENTRY_W-1:0]  i_entry,
    input  logic                i_is_write,
    input  logic                i_slot_free,
    output t_beat               o_beat,
    output logic                o_ram_we,
    output logic [IDX_W-1:0]    o_ram_waddr,
    output logic [SECTOR_W-1:0] o_ram_wdata,
    output logic                o_ram_re,
    output logic [IDX_W-1:0]    o_ram_raddr,
    input  logic [SECTOR_W-1:0] i_ram_rdata
);

    t_state                 r_state, n_state;
    logic [NUM_ENTRIES-1:0] r_dirty, n_dirty;
    logic [NUM_ENTRIES-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [IDX_W-1:0]       r_hand, n_hand;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_victim, n_victim;
    logic [SECTOR_W-1:0]    r_sector, n_sector;
    logic                   r_pend, n_pend;

    logic             full;
    logic             scan_done;
    logic             take;
    logic [IDX_W-1:0] cur;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] h);
        logic [IDX_W-1:0] nxt;
        nxt = (h == IDX_W'(NUM_ENTRIES - 1)) ? '0 : h + 1'b1;
        return nxt;
    endfunction

    // valid entries always form a prefix, tracked by the fill count
    assign full       = (r_fill == CNT_W'(NUM_ENTRIES));
    assign scan_done  = (r_idx == CNT_W'(NUM_ENTRIES));
    assign cur        = r_idx[IDX_W-1:0];
    assign take       = o_beat.valid && i_slot_free;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_MISS:  n_state = full ? ST_SWEEP : ST_RD;
                        KIND_FLUSH: n_state = ST_FL_SCAN;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (!r_acc[cur]) begin
                    n_state = r_dirty[cur] ? ST_WB : ST_RD;
                end
            end
            ST_WB: begin
                if (take) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (take) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FL_SCAN: begin
                if (scan_done) begin
                    n_state = r_pend ? ST_FL_LAST : ST_IDLE;
                end
            end
            ST_FL_LAST: begin
                if (take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_dirty     = r_dirty;
        n_acc       = r_acc;
        n_fill      = r_fill;
        n_hand      = r_hand;
        n_idx       = r_idx;
        n_victim    = r_victim;
        n_sector    = r_sector;
        n_pend      = r_pend;
        o_beat      = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_victim;
        o_ram_wdata = r_sector;
        o_ram_re    = 1'b0;
        o_ram_raddr = cur;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_MISS: begin
                            n_sector = i_sector;
                            if (!full) begin
                                n_victim                    = r_fill[IDX_W-1:0];
                                o_ram_we                    = 1'b1;
                                o_ram_waddr                 = r_fill[IDX_W-1:0];
                                o_ram_wdata                 = i_sector;
                                n_fill                      = r_fill + 1'b1;
                                n_dirty[r_fill[IDX_W-1:0]] = 1'b0;
                                n_acc[r_fill[IDX_W-1:0]]   = 1'b0;
                            end else begin
                                n_idx = CNT_W'(r_hand);
                            end
                        end
                        KIND_TOUCH: begin
                            if (7'(i_entry) < 7'(r_fill)) begin
                                n_acc[i_entry[IDX_W-1:0]] = 1'b1;
                                if (i_is_write) begin
                                    n_dirty[i_entry[IDX_W-1:0]] = 1'b1;
                                end
                            end
                        end
                        KIND_FLUSH: begin
                            n_idx  = '0;
                            n_pend = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (r_acc[cur]) begin
                    n_acc[cur] = 1'b0;
                    n_idx      = CNT_W'(next_slot(cur));
                end else begin
                    n_victim = cur;
                    n_hand   = next_slot(cur);
                    if (r_dirty[cur]) begin
                        // old tag comes back next cycle for the write-back
                        o_ram_re = 1'b1;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = cur;
                    end
                end
            end
            ST_WB: begin
                o_beat.valid  = 1'b1;
                o_beat.action = ACT_WRITE_BACK;
                o_beat.sector = i_ram_rdata;
                o_beat.entry  = ENTRY_W'(r_victim);
                o_beat.last   = 1'b0;
                if (take) begin
                    o_ram_we          = 1'b1;
                    n_dirty[r_victim] = 1'b0;
                    n_acc[r_victim]   = 1'b0;
                end
            end
            ST_RD: begin
                o_beat.valid  = 1'b1;
                o_beat.action = ACT_READ;
                o_beat.sector = r_sector;
                o_beat.entry  = ENTRY_W'(r_victim);
                o_beat.last   = 1'b1;
            end
            ST_FL_SCAN: begin
                if (!scan_done) begin
                    if (r_dirty[cur]) begin
                        // a further dirty entry exists, so the pending one is not last
                        if (r_pend) begin
                            o_beat.valid  = 1'b1;
                            o_beat.action = ACT_WRITE_BACK;
                            o_beat.sector = i_ram_rdata;
                            o_beat.entry  = ENTRY_W'(r_victim);
                            o_beat.last   = 1'b0;
                        end
                        if (!r_pend || take) begin
                            n_dirty[cur] = 1'b0;
                            o_ram_re     = 1'b1;
                            n_victim     = cur;
                            n_pend       = 1'b1;
                            n_idx        = r_idx + 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FL_LAST: begin
                o_beat.valid  = 1'b1;
                o_beat.action = ACT_WRITE_BACK;
                o_beat.sector = i_ram_rdata;
                o_beat.entry  = ENTRY_W'(r_victim);
                o_beat.last   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dirty <= '0;
            r_acc   <= '0;
            r_fill  <= '0;
            r_hand  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
            r_acc   <= n_acc;
            r_fill  <= n_fill;
            r_hand  <= n_hand;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_victim <= n_victim;
        r_sector <= n_sector;
    end

endmodule

### hdl/clock_buffer_cache_replacement_core.sv
`timescale 1ns / 1ps

// Channel  Handshake          Payload
// -------  -----------------  ------------------------------------------------
// in       i_valid / o_ready  i_kind, i_sector, i_entry, i_is_write
// out      o_valid / i_ready  o_action, o_out_sector, o_out_entry, o_last
//
// Touch and unused kinds are handled in IDLE. Miss with a free entry: tag write, then the read beat.
// Miss when full: up to NUM_ENTRIES+1 clock-hand steps, then 1 or 2 beats; the sweep
// moves one entry per cycle. Flush: one write-back beat per dirty entry, the final one
// marked last; the scan visits one entry per cycle, except while a write-back beat waits
// on the output, through the tag RAM read port.
// Synchronous active-low reset clears marks, fill count and hand at once (no clearing pass).
// A stalled output holds the sequencer; o_ready is low until the item is finished.

module clock_buffer_cache_replacement_core
    import cbcr_pkg::*;
#(
    parameter int NUM_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SECTOR_W-1:0] i_sector,
    input  logic [ENTRY_W-1:0]  i_entry,
    input  logic                i_is_write,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_action,
    output logic [SECTOR_W-1:0] o_out_sector,
    output logic [ENTRY_W-1:0]  o_out_entry,
    output logic                o_last
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    t_beat               beat;
    logic                slot_free;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [SECTOR_W-1:0] ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [SECTOR_W-1:0] ram_rdata;

    logic                r_o_valid;
    logic                r_action;
    logic [SECTOR_W-1:0] r_sector;
    logic [ENTRY_W-1:0]  r_entry;
    logic                r_last;

    assign slot_free = !r_o_valid || i_ready;

    cbcr_seq #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_kind      (i_kind),
        .i_sector    (i_sector),
        .i_entry     (i_entry),
        .i_is_write  (i_is_write),
        .i_slot_free (slot_free),
        .o_beat      (beat),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    cbcr_tag_ram #(
        .DEPTH  (NUM_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register: one beat buffered toward the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (beat.valid && slot_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat.valid && slot_free) begin
            r_action <= beat.action;
            r_sector <= beat.sector;
            r_entry  <= beat.entry;
            r_last   <= beat.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_action     = r_action;
    assign o_out_sector = r_sector;
    assign o_out_entry  = r_entry;
    assign o_last       = r_last;

endmodule
